// ===== hw/rtl/npcm_pkg.sv =====
// Shared types and constants for the nearest palette color match block.
// No dependencies.
`timescale 1ns / 1ps

package npcm_pkg;

  localparam int COLOR_W = 8;
  localparam int DIST_W  = 10;   // 3 * 255 = 765 fits in 10 bits
  localparam int BEST_W  = 16;
  localparam logic [BEST_W-1:0] NO_DIST = 16'hFFFF;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  localparam int RGB_W = $bits(rgb_t);

endpackage

// ===== hw/rtl/npcm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module npcm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/npcm_dist.sv =====
// Manhattan distance between a pixel and one palette entry.
// Depends on npcm_pkg.
`timescale 1ns / 1ps

module npcm_dist
  import npcm_pkg::*;
(
  input  rgb_t              pixel,
  input  rgb_t              entry,
  output logic [DIST_W-1:0] dist_sum
);

  function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
    return (a < b) ? (b - a) : (a - b);
  endfunction

  assign dist_sum = DIST_W'(abs_diff(pixel.red,   entry.red))
                  + DIST_W'(abs_diff(pixel.green, entry.green))
                  + DIST_W'(abs_diff(pixel.blue,  entry.blue));

endmodule

// ===== hw/rtl/nearest_palette_color_match.sv =====
// Top level of the nearest palette color match block.
// Depends on npcm_pkg, npcm_ram and npcm_dist.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall): mode 0 writes red/green/blue into
//   palette slot entry_index (ignored when the slot is not below
//   PALETTE_DEPTH); mode 1 matches the pixel and yields one transaction on
//   the output channel (out_valid / out_stall) carrying color_index.
//   cfg_wr_en / cfg_wr_data load palette_size; write it only while idle.
// Timing
//   A match scans N = min(palette_size, PALETTE_DEPTH) entries: the scan
//   reads one palette entry per cycle through the memory's single read
//   port, then takes the last entry's registered read data, sees the scan
//   drained and moves to the load state, which loads the result; an empty
//   palette goes straight from the scan state to the load state.
//   in_stall is high for the whole scan and the load state; the next
//   transaction is taken the cycle after the result is registered.
// Reset
//   rst_n (synchronous, active low) clears palette_size, the FSM and
//   out_valid. Palette contents are undefined until written.
// Backpressure
//   The result sits in an output register while out_stall is high. Writes
//   keep being accepted meanwhile; a finished match waits in the load
//   state until the output register is free.

module nearest_palette_color_match
  import npcm_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_wr_en,
  input  logic [8:0]           cfg_wr_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_mode,
  input  logic [7:0]           in_entry_index,
  input  logic [COLOR_W-1:0]   in_red,
  input  logic [COLOR_W-1:0]   in_green,
  input  logic [COLOR_W-1:0]   in_blue,
  // output channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_color_index
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int CW = $clog2(PALETTE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t            state_r, state_nxt;
  logic [8:0]        cfg_size_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     iss_cnt_r, iss_cnt_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]     rd_idx_r, rd_idx_nxt;
  rgb_t              px_r, px_nxt;
  logic [BEST_W-1:0] best_dist_r, best_dist_nxt;
  logic [AW-1:0]     best_idx_r, best_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_idx_r, out_idx_nxt;

  logic              in_acc;
  logic              in_range;
  logic              ram_wr_en;
  logic              ram_rd_en;
  logic [RGB_W-1:0]  ram_rd_data;
  logic [DIST_W-1:0] cand_dist;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_range = ({1'b0, in_entry_index} < 9'(PALETTE_DEPTH));
  assign ram_wr_en = in_acc && !in_mode && in_range;
  assign ram_rd_en = (state_r == ST_SCAN) && (iss_cnt_r < count_r);

  npcm_ram #(
    .WIDTH(RGB_W),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(in_entry_index[AW-1:0]),
    .wr_data({in_red, in_green, in_blue}),
    .rd_en  (ram_rd_en),
    .rd_addr(iss_cnt_r[AW-1:0]),
    .rd_data(ram_rd_data)
  );

  npcm_dist u_dist (
    .pixel   (px_r),
    .entry   (rgb_t'(ram_rd_data)),
    .dist_sum(cand_dist)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    iss_cnt_nxt   = iss_cnt_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    px_nxt        = px_r;
    best_dist_nxt = best_dist_r;
    best_idx_nxt  = best_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_idx_nxt   = out_idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_mode) begin
          px_nxt        = '{red: in_red, green: in_green, blue: in_blue};
          // size above depth saturates
          count_nxt     = (cfg_size_r >= 9'(PALETTE_DEPTH)) ? CW'(PALETTE_DEPTH)
                                                            : CW'(cfg_size_r);
          iss_cnt_nxt   = '0;
          best_dist_nxt = NO_DIST;
          best_idx_nxt  = '0;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ram_rd_en) begin
          rd_vld_nxt  = 1'b1;
          rd_idx_nxt  = iss_cnt_r[AW-1:0];
          iss_cnt_nxt = iss_cnt_r + 1'b1;
        end
        // strict less-than keeps the lowest index on ties
        if (rd_vld_r && (BEST_W'(cand_dist) < best_dist_r)) begin
          best_dist_nxt = BEST_W'(cand_dist);
          best_idx_nxt  = rd_idx_r;
        end
        if (!ram_rd_en && !rd_vld_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = 8'(best_idx_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_size_r  <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_size_r <= cfg_wr_data;
      end
    end
    count_r     <= count_nxt;
    iss_cnt_r   <= iss_cnt_nxt;
    rd_idx_r    <= rd_idx_nxt;
    px_r        <= px_nxt;
    best_dist_r <= best_dist_nxt;
    best_idx_r  <= best_idx_nxt;
    out_idx_r   <= out_idx_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_color_index = out_idx_r;

  // A new result only appears right after the load state.
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_FINISH))
    else $error("result appeared outside the load state");

  // Palette is never written while a scan reads it.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> (state_r == ST_IDLE))
    else $error("palette write during scan");

  // Returned read data always belongs to an entry inside the scan range.
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (CW'(rd_idx_r) < count_r))
    else $error("palette read beyond scan count");

  // Reported index stays inside the palette.
  a_index_in_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_color_index} < 9'(PALETTE_DEPTH)))
    else $error("color index beyond palette depth");

endmodule
